[sv/pcse_pkg.sv]
// ----------------------------------------------------------------------------
// pcse_pkg
// Shared types, register indexes, reset values and helpers for the pulse
// channel with frequency sweep and volume envelope.
// ----------------------------------------------------------------------------
`default_nettype none

package pcse_pkg;

  // Operation carried by one input transaction
  typedef enum logic [2:0] {
    FN_WRITE    = 3'd0,
    FN_READ     = 3'd1,
    FN_ADVANCE  = 3'd2,
    FN_LENGTH   = 3'd3,
    FN_ENVELOPE = 3'd4,
    FN_SWEEP    = 3'd5
  } pcse_func_t;

  // Register indexes
  localparam logic [2:0] REG_SWEEP  = 3'd0;
  localparam logic [2:0] REG_DUTY   = 3'd1;
  localparam logic [2:0] REG_ENV    = 3'd2;
  localparam logic [2:0] REG_PER_LO = 3'd3;
  localparam logic [2:0] REG_PER_HI = 3'd4;

  // Register reset values
  localparam logic [7:0] SWEEP_RST  = 8'h80;
  localparam logic [7:0] DUTY_RST   = 8'hBF;
  localparam logic [7:0] ENV_RST    = 8'hF3;
  localparam logic [7:0] PER_LO_RST = 8'h00;
  localparam logic [7:0] PER_HI_RST = 8'hBF;

  localparam logic [6:0] LENGTH_END = 7'd64;
  localparam logic [3:0] VOL_MAX    = 4'd15;

  // Waveform bit for a duty setting and a step position
  function automatic logic pcse_duty_bit(input logic [1:0] duty, input logic [2:0] pos);
    logic [7:0] pattern;
    begin
      unique case (duty)
        2'd0: pattern = 8'b1111_0000;
        2'd1: pattern = 8'b1111_1000;
        2'd2: pattern = 8'b0011_1100;
        default: pattern = 8'b0000_1111;
      endcase
      return pattern[pos];
    end
  endfunction

  // Timer reload: (2048 - period) * 4
  function automatic logic [13:0] pcse_reload(input logic [10:0] period);
    logic [11:0] span;
    begin
      span = 12'd2048 - {1'b0, period};
      return {span, 2'b00};
    end
  endfunction

endpackage : pcse_pkg

`default_nettype wire

[sv/pulse_channel_sweep_envelope.sv]
// ----------------------------------------------------------------------------
// pulse_channel_sweep_envelope
// Square-wave sound channel: register file, trigger, frequency timer, duty
// step, length counter, volume envelope and frequency sweep.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                          | tuser
//  --------+-----------+---------------------------------------------+------
//  in_     | slave     | reg_select[2:0] write_value[10:3]           | func
//          |           | cycle_count[18:11], zero pad [23:19]        |
//  out_    | master    | read_value[7:0] sample_level[11:8]          | -
//          |           | channel_on[12] dac_on[13], zero pad [15:14] |
//
//  One transaction per clock while the output is not stalled. An accepted
//  transaction sits in the input register; the channel state updates and the
//  result is captured when it moves to the output register.
//  rst_n (synchronous, active low) empties both registers and loads the
//  register file and channel state with their power-up values.
//  A stalled output holds the input register; the input accepts again as
//  soon as the input register is empty or moving on.
//
`default_nettype none

module pulse_channel_sweep_envelope (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [23:0]              in_tdata,   // reg_select, write_value, cycle_count
  input  wire  pcse_pkg::pcse_func_t in_tuser, // func
  output logic                     out_tvalid,
  input  wire                      out_tready,
  output logic [15:0]              out_tdata   // read_value, sample_level, channel_on, dac_on
);
  import pcse_pkg::*;

  // Input register
  logic        in_valid_r;
  pcse_func_t  func_r;
  logic [2:0]  sel_r;
  logic [7:0]  wval_r;
  logic [7:0]  cyc_r;

  // Output register
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic [15:0] out_data_nxt;

  // Channel state
  logic [7:0]  sweep_r, duty_r, env_r, per_lo_r, per_hi_r;
  logic [7:0]  sweep_nxt, duty_nxt, env_nxt, per_lo_nxt, per_hi_nxt;
  logic        en_r, dac_r, en_nxt, dac_nxt;
  logic [6:0]  len_r, len_nxt;
  logic [2:0]  env_pace_r, env_pace_nxt;
  logic [2:0]  env_cnt_r, env_cnt_nxt;
  logic        env_rise_r, env_rise_nxt;
  logic [3:0]  vol_r, vol_nxt;
  logic [13:0] freq_cnt_r, freq_cnt_nxt;
  logic [2:0]  duty_pos_r, duty_pos_nxt;
  logic [2:0]  sweep_cnt_r, sweep_cnt_nxt;

  logic        advance;
  logic [10:0] period;
  logic [10:0] delta;
  logic [11:0] sweep_sum;
  logic [7:0]  rd_val;
  logic [3:0]  sample;

  // Pipeline moves when the output slot is free or being drained
  assign advance    = !out_valid_r || out_tready;
  assign in_tready  = !in_valid_r || advance;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign period    = {per_hi_r[2:0], per_lo_r};
  assign delta     = period >> sweep_r[2:0];
  assign sweep_sum = {1'b0, period} + {1'b0, delta};

  always_comb begin
    sweep_nxt     = sweep_r;
    duty_nxt      = duty_r;
    env_nxt       = env_r;
    per_lo_nxt    = per_lo_r;
    per_hi_nxt    = per_hi_r;
    en_nxt        = en_r;
    dac_nxt       = dac_r;
    len_nxt       = len_r;
    env_pace_nxt  = env_pace_r;
    env_cnt_nxt   = env_cnt_r;
    env_rise_nxt  = env_rise_r;
    vol_nxt       = vol_r;
    freq_cnt_nxt  = freq_cnt_r;
    duty_pos_nxt  = duty_pos_r;
    sweep_cnt_nxt = sweep_cnt_r;
    rd_val        = 8'd0;

    unique case (func_r)
      FN_WRITE: begin
        unique case (sel_r)
          REG_SWEEP:  sweep_nxt  = wval_r;
          REG_DUTY:   duty_nxt   = wval_r;
          REG_ENV:    env_nxt    = wval_r;
          REG_PER_LO: per_lo_nxt = wval_r;
          REG_PER_HI: begin
            per_hi_nxt = wval_r;
            // Trigger: DAC off when the envelope's upper five bits are clear
            if (wval_r[7]) begin
              if (env_r[7:3] == 5'd0) begin
                dac_nxt = 1'b0;
                en_nxt  = 1'b0;
              end else begin
                dac_nxt       = 1'b1;
                en_nxt        = 1'b1;
                len_nxt       = {1'b0, duty_r[5:0]};
                env_pace_nxt  = env_r[2:0];
                env_cnt_nxt   = env_r[2:0];
                env_rise_nxt  = env_r[3];
                vol_nxt       = env_r[7:4];
                freq_cnt_nxt  = pcse_reload({wval_r[2:0], per_lo_r});
                duty_pos_nxt  = 3'd0;
                sweep_cnt_nxt = sweep_r[6:4];
              end
            end
          end
          default: ;
        endcase
      end
      FN_READ: begin
        unique case (sel_r)
          REG_SWEEP:  rd_val = sweep_r;
          REG_DUTY:   rd_val = duty_r;
          REG_ENV:    rd_val = env_r;
          REG_PER_LO: rd_val = per_lo_r;
          REG_PER_HI: rd_val = per_hi_r;
          default:    rd_val = 8'd0;
        endcase
      end
      FN_ADVANCE: begin
        if (en_r) begin
          if (freq_cnt_r <= {6'd0, cyc_r}) begin
            freq_cnt_nxt = pcse_reload(period);
            duty_pos_nxt = duty_pos_r + 3'd1;
          end else begin
            freq_cnt_nxt = freq_cnt_r - {6'd0, cyc_r};
          end
        end
      end
      FN_LENGTH: begin
        // Length counts only with the length-enable bit set
        if (per_hi_r[6] && (len_r < LENGTH_END)) begin
          len_nxt = len_r + 7'd1;
          if (len_nxt == LENGTH_END) begin
            en_nxt = 1'b0;
          end
        end
      end
      FN_ENVELOPE: begin
        if (env_pace_r != 3'd0) begin
          if (env_cnt_r <= 3'd1) begin
            env_cnt_nxt = env_pace_r;
            if (env_rise_r) begin
              if (vol_r < VOL_MAX) vol_nxt = vol_r + 4'd1;
            end else begin
              if (vol_r != 4'd0) vol_nxt = vol_r - 4'd1;
            end
          end else begin
            env_cnt_nxt = env_cnt_r - 3'd1;
          end
        end
      end
      FN_SWEEP: begin
        if ((sweep_r[6:4] != 3'd0) && en_r) begin
          if (sweep_cnt_r > 3'd1) begin
            sweep_cnt_nxt = sweep_cnt_r - 3'd1;
          end else begin
            sweep_cnt_nxt = sweep_r[6:4];
            if (!sweep_r[3]) begin
              // Add: overflow past the 11-bit period shuts the channel
              if (sweep_sum[11]) begin
                en_nxt = 1'b0;
              end else begin
                per_lo_nxt = sweep_sum[7:0];
                per_hi_nxt = {per_hi_r[7:3], sweep_sum[10:8]};
              end
            end else begin
              {per_hi_nxt[2:0], per_lo_nxt} = period - delta;
            end
          end
        end
      end
      default: ;
    endcase

    // Sample reflects the state after this transaction
    sample = 4'd0;
    if (dac_nxt && en_nxt && pcse_duty_bit(duty_nxt[7:6], duty_pos_nxt)) begin
      sample = vol_nxt;
    end
    out_data_nxt = {2'b00, dac_nxt, en_nxt, sample, rd_val};
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      func_r <= in_tuser;
      sel_r  <= in_tdata[2:0];
      wval_r <= in_tdata[10:3];
      cyc_r  <= in_tdata[18:11];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
    if (advance && in_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Channel state: commit when a transaction leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= SWEEP_RST;
      duty_r      <= DUTY_RST;
      env_r       <= ENV_RST;
      per_lo_r    <= PER_LO_RST;
      per_hi_r    <= PER_HI_RST;
      en_r        <= 1'b0;
      dac_r       <= 1'b0;
      len_r       <= 7'd0;
      env_pace_r  <= 3'd0;
      env_cnt_r   <= 3'd0;
      env_rise_r  <= 1'b0;
      vol_r       <= 4'd0;
      freq_cnt_r  <= 14'd0;
      duty_pos_r  <= 3'd0;
      sweep_cnt_r <= 3'd0;
    end else if (advance && in_valid_r) begin
      sweep_r     <= sweep_nxt;
      duty_r      <= duty_nxt;
      env_r       <= env_nxt;
      per_lo_r    <= per_lo_nxt;
      per_hi_r    <= per_hi_nxt;
      en_r        <= en_nxt;
      dac_r       <= dac_nxt;
      len_r       <= len_nxt;
      env_pace_r  <= env_pace_nxt;
      env_cnt_r   <= env_cnt_nxt;
      env_rise_r  <= env_rise_nxt;
      vol_r       <= vol_nxt;
      freq_cnt_r  <= freq_cnt_nxt;
      duty_pos_r  <= duty_pos_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
    end
  end

endmodule : pulse_channel_sweep_envelope

`default_nettype wire
